/* src/kmp_pkg.sv */
`default_nettype none

package kmp_pkg;

  // pattern capacity in bytes
  localparam int unsigned MaxPattern = 256;
  // store address width and length width (holds 0..MaxPattern)
  localparam int unsigned AddrW = $clog2(MaxPattern);
  localparam int unsigned LenW  = $clog2(MaxPattern + 1);
  // reported length field width
  localparam int unsigned OutLenW = 9;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [7:0]       byte_t;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2
  } action_e;

  // request from the sequencer to the pattern and prefix stores
  typedef struct packed {
    logic  we;
    addr_t waddr;
    byte_t wpat;
    len_t  wpref;
    logic  re;
    addr_t pat_raddr;
    addr_t pref_raddr;
  } store_req_t;

  // fit an internal length into the reported field, masking or zero-extending
  function automatic logic [OutLenW-1:0] to_out_len(input len_t v);
    logic [LenW+OutLenW-1:0] wide;
    wide = {{OutLenW{1'b0}}, v};
    return wide[OutLenW-1:0];
  endfunction

endpackage

`default_nettype wire

/* src/kmp_store.sv */
`default_nettype none

module kmp_store import kmp_pkg::*; (
  input  logic       clk_i,
  input  store_req_t req_i,
  output byte_t      pat_rd_o,
  output len_t       pref_rd_o
);

  byte_t pat_mem  [MaxPattern];
  len_t  pref_mem [MaxPattern];

  byte_t pat_rd_q;
  len_t  pref_rd_q;

  // one write port shared by both stores, one registered read port each
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      pat_mem[req_i.waddr]  <= req_i.wpat;
      pref_mem[req_i.waddr] <= req_i.wpref;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      pat_rd_q  <= pat_mem[req_i.pat_raddr];
      pref_rd_q <= pref_mem[req_i.pref_raddr];
    end
  end

  assign pat_rd_o  = pat_rd_q;
  assign pref_rd_o = pref_rd_q;

endmodule

`default_nettype wire

/* src/kmp_stream_matcher.sv */
`default_nettype none
// clear, unused action, full store, empty pattern and first pattern byte: answered from idle
// other words: FETCH, LOAD if border fetched, READ, CMP per compare, k fallbacks: k + 1 compares
// one word at a time; fallbacks amortise to about two compares per word
// compares read both stores through their own registered read ports, so each is READ then CMP
// reset: asynchronous, clears sequencer, lengths and output valid; stores are not cleared
// a finished result must leave before the next word is taken; both may happen on one edge

module kmp_stream_matcher import kmp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          action_i,
  input  logic [7:0]          ch_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutLenW-1:0]  length_o,
  output logic                full_match_o,
  output logic                overflow_o
);

  // one-hot sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,  // read prefix of the last pattern byte
    ST_LOAD  = 5'b00100,  // take that prefix as the start border
    ST_READ  = 5'b01000,  // read pattern[j] and prefix[j-1]
    ST_CMP   = 5'b10000   // compare, fall back or finish
  } state_e;

  state_e st_q, st_d;
  logic   pat_q, pat_d;       // current word is a pattern byte (else text)
  byte_t  ch_q, ch_d;
  len_t   j_q, j_d;           // border under test
  len_t   plen_q, plen_d;     // pattern length
  len_t   mlen_q, mlen_d;     // matched length

  logic   out_valid_q, out_valid_d;
  len_t   out_len_q, out_len_d;
  logic   out_full_q, out_full_d;
  logic   out_ovf_q, out_ovf_d;

  store_req_t req;
  byte_t      pat_rd;
  len_t       pref_rd;

  logic    slot_free;
  logic    in_acc;
  action_e act;
  logic    hit;
  logic    done;
  len_t    j_fin;
  len_t    j_back;
  len_t    j_start;

  kmp_store u_store (
    .clk_i     (clk_i),
    .req_i     (req),
    .pat_rd_o  (pat_rd),
    .pref_rd_o (pref_rd)
  );

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (st_q == ST_IDLE) && slot_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign act        = action_e'(action_i);

  // compare step: stop on a hit or at the empty border
  assign hit    = (pat_rd == ch_q);
  assign done   = (j_q == '0) || hit;
  assign j_fin  = (hit && (j_q < plen_q)) ? j_q + len_t'(1) : j_q;
  // fall back along the prefix chain; a non-shrinking value ends at zero
  assign j_back  = (pref_rd < j_q) ? pref_rd : '0;
  assign j_start = (pref_rd >= plen_q) ? '0 : pref_rd;

  always_comb begin
    st_d        = st_q;
    pat_d       = pat_q;
    ch_d        = ch_q;
    j_d         = j_q;
    plen_d      = plen_q;
    mlen_d      = mlen_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_len_d   = out_len_q;
    out_full_d  = out_full_q;
    out_ovf_d   = out_ovf_q;

    req            = '0;
    req.waddr      = plen_q[AddrW-1:0];
    req.wpat       = ch_q;
    req.wpref      = j_fin;
    req.pat_raddr  = j_q[AddrW-1:0];
    req.pref_raddr = addr_t'(j_q - len_t'(1));

    case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          ch_d       = ch_i;
          out_len_d  = '0;
          out_full_d = 1'b0;
          out_ovf_d  = 1'b0;
          case (act)
            ACT_CLEAR: begin
              plen_d      = '0;
              mlen_d      = '0;
              out_valid_d = 1'b1;
            end
            ACT_PATTERN: begin
              pat_d = 1'b1;
              if (plen_q == len_t'(MaxPattern)) begin
                out_ovf_d   = 1'b1;
                out_valid_d = 1'b1;
              end else if (plen_q == '0) begin
                // first byte has an empty border
                req.we      = 1'b1;
                req.wpat    = ch_i;
                req.wpref   = '0;
                plen_d      = len_t'(1);
                out_valid_d = 1'b1;
              end else begin
                st_d = ST_FETCH;
              end
            end
            ACT_TEXT: begin
              pat_d = 1'b0;
              if (plen_q == '0) begin
                mlen_d      = '0;
                out_valid_d = 1'b1;
              end else if (mlen_q >= plen_q) begin
                // after a full match, fall back before extending
                st_d = ST_FETCH;
              end else begin
                j_d  = mlen_q;
                st_d = ST_READ;
              end
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_FETCH: begin
        req.re         = 1'b1;
        req.pref_raddr = addr_t'(plen_q - len_t'(1));
        st_d           = ST_LOAD;
      end
      ST_LOAD: begin
        j_d  = j_start;
        st_d = ST_READ;
      end
      ST_READ: begin
        req.re = 1'b1;
        st_d   = ST_CMP;
      end
      ST_CMP: begin
        if (!done) begin
          j_d  = j_back;
          st_d = ST_READ;
        end else if (slot_free) begin
          out_valid_d = 1'b1;
          out_len_d   = j_fin;
          if (pat_q) begin
            req.we = 1'b1;
            plen_d = plen_q + len_t'(1);
          end else begin
            mlen_d     = j_fin;
            out_full_d = (j_fin == plen_q);
          end
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      pat_q       <= 1'b0;
      j_q         <= '0;
      plen_q      <= '0;
      mlen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      pat_q       <= pat_d;
      j_q         <= j_d;
      plen_q      <= plen_d;
      mlen_q      <= mlen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    out_len_q  <= out_len_d;
    out_full_q <= out_full_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o  = out_valid_q;
  assign length_o     = to_out_len(out_len_q);
  assign full_match_o = out_full_q;
  assign overflow_o   = out_ovf_q;

`ifndef ASSERT_OFF
  a_plen_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= len_t'(MaxPattern))
    else $error("pattern length beyond capacity");

  a_mlen_le_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mlen_q <= plen_q)
    else $error("matched length beyond pattern length");

  a_border_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_READ || st_q == ST_CMP) |-> j_q < plen_q)
    else $error("border under test not inside pattern");

  a_ovf_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> (length_o == '0 && !full_match_o))
    else $error("dropped byte reported with a length or match");

  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_full_q) |-> (out_len_q == plen_q && plen_q != '0))
    else $error("full match without a whole nonempty pattern");
`endif

endmodule

`default_nettype wire

/* test/kmp_stream_matcher_tb.sv */
`timescale 1ns / 1ps

module kmp_stream_matcher_tb;
  import kmp_pkg::*;

  // the block has no code for the spare action value, so name it here
  localparam logic [1:0] ActUnused = 2'd3;

  // idle cycles with no word moving on either side before the run is abandoned
  localparam int unsigned WatchdogLimit = 5000;
  // settle time after the last result, to catch stray output words
  localparam int unsigned TailCycles = 32;
  // random words wanted after the directed part and the full store phase
  localparam int unsigned RandomWords = 120;

  typedef struct packed {
    logic [OutLenW-1:0] length;
    logic               full_match;
    logic               overflow;
  } match_res_t;

  // golden copy of the matcher: pattern, border table and match progress
  class kmp_match_predictor;
    byte_t       pat_mem [MaxPattern];
    int unsigned border_mem [MaxPattern];
    int unsigned pat_len;
    int unsigned match_len;
    match_res_t  pending_q [$];

    int unsigned errors;
    int unsigned results_seen;
    int unsigned n_clear, n_pattern, n_text, n_unused;
    int unsigned n_full, n_overflow, max_len;

    function void note_word(input logic [1:0] act, input byte_t c);
      match_res_t  res;
      int unsigned j;
      res = '0;
      j   = 0;
      case (act)
        ACT_CLEAR: begin
          pat_len   = 0;
          match_len = 0;
          n_clear++;
        end
        ACT_PATTERN: begin
          n_pattern++;
          if (pat_len >= MaxPattern) begin
            res.overflow = 1'b1;
            n_overflow++;
          end else begin
            // longest border of the grown pattern, walking back through shorter borders
            if (pat_len > 0) begin
              j = border_mem[pat_len - 1];
              while (j > 0 && pat_mem[j] != c) j = border_mem[j - 1];
              if (pat_mem[j] == c) j++;
            end
            pat_mem[pat_len]    = c;
            border_mem[pat_len] = j;
            pat_len++;
          end
        end
        ACT_TEXT: begin
          n_text++;
          if (pat_len == 0) begin
            match_len = 0;
          end else begin
            j = match_len;
            // after a whole match, drop back to the border of the full pattern first
            if (j >= pat_len) j = border_mem[pat_len - 1];
            while (j > 0 && pat_mem[j] != c) j = border_mem[j - 1];
            if (pat_mem[j] == c) j++;
            match_len      = j;
            res.full_match = (j == pat_len);
            if (res.full_match) n_full++;
          end
        end
        default: n_unused++;
      endcase
      res.length = j[OutLenW-1:0];
      if (j > max_len) max_len = j;
      pending_q.insert(pending_q.size(), res);
    endfunction

    function void report(input string msg);
      errors++;
      if (errors <= 10) $display("error %0d: %s", errors, msg);
    endfunction

    function void check_result(input logic [OutLenW-1:0] len, input logic full,
                               input logic ovf);
      match_res_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", results_seen));
        return;
      end
      want = pending_q.pop_front();
      if (len !== want.length || full !== want.full_match || ovf !== want.overflow)
        report($sformatf({"result %0d: length exp %0d got %0d, full_match exp %b got %b,",
                          " overflow exp %b got %b"}, results_seen, want.length, len,
                         want.full_match, full, want.overflow, ovf));
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         action_i;
  logic [7:0]         ch_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [OutLenW-1:0] length_o;
  logic               full_match_o;
  logic               overflow_o;

  kmp_stream_matcher u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .action_i    (action_i),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .length_o    (length_o),
    .full_match_o(full_match_o),
    .overflow_o  (overflow_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  kmp_match_predictor sb = new();

  int unsigned burst_left;
  int unsigned sent_words;
  int unsigned idle_cycles;
  int unsigned ready_mode;
  int unsigned ready_mode_left;
  int unsigned ready_phase;

  // monitor: note words going in, check words coming out, run the receiver
  // stall pattern and the watchdog, all on values sampled before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(action_i, ch_i);
      if (out_valid_o && out_ready_i) sb.check_result(length_o, full_match_o, overflow_o);

      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending());
        $display("== FAIL ==");
        $finish;
      end
    end

    // receiver switches between free running, coin toss, one in four and heavy stalling
    if (ready_mode_left == 0) begin
      ready_mode      = $urandom_range(0, 3);
      ready_mode_left = $urandom_range(40, 300);
    end
    ready_mode_left--;
    ready_phase++;
    case (ready_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= (ready_phase % 4 == 0);
      default: out_ready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // present one word and hold it until taken; bursts of random length, mostly with gaps between
  task automatic send_word(input logic [1:0] act, input logic [7:0] c);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    action_i   <= act;
    ch_i       <= c;
    do @(posedge clk_i); while (!in_ready_o);
    if (act != ActUnused) sent_words++;
  endtask

  initial begin
    byte_t       motif [3];
    byte_t       alpha [3];
    int unsigned period;
    int unsigned alpha_n;
    int unsigned plen;
    int unsigned mark;

    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_CLEAR;
    ch_i        <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: text against an empty pattern, the spare action, then "aba"
    send_word(ACT_TEXT, 8'h61);
    send_word(ActUnused, 8'hff);
    send_word(ACT_CLEAR, 8'hff);
    send_word(ACT_PATTERN, 8'h61);
    send_word(ACT_PATTERN, 8'h62);
    send_word(ACT_PATTERN, 8'h61);
    // whole match, then the word after it falls back to the border first
    send_word(ACT_TEXT, 8'h61);
    send_word(ACT_TEXT, 8'h62);
    send_word(ACT_TEXT, 8'h61);
    send_word(ACT_TEXT, 8'h62);
    send_word(ACT_TEXT, 8'h61);
    // pattern grown after a match keeps the match progress
    send_word(ACT_PATTERN, 8'h62);
    send_word(ACT_TEXT, 8'h62);
    // byte extremes, a mismatch back to zero and the spare action mid stream
    send_word(ACT_TEXT, 8'h00);
    send_word(ACT_TEXT, 8'hff);
    send_word(ACT_PATTERN, 8'hff);
    send_word(ACT_TEXT, 8'h61);
    send_word(ActUnused, 8'h00);
    send_word(ACT_TEXT, 8'h62);
    send_word(ACT_TEXT, 8'h61);
    send_word(ACT_TEXT, 8'h62);
    send_word(ACT_TEXT, 8'hff);
    send_word(ACT_CLEAR, 8'h00);
    send_word(ACT_TEXT, 8'h00);

    // fill the store with a periodic pattern, overrun it, and scan it with long fallbacks
    send_word(ACT_CLEAR, 8'($urandom_range(0, 255)));
    period = $urandom_range(1, 3);
    foreach (motif[k]) motif[k] = byte_t'($urandom_range(0, 255));
    for (int i = 0; i < MaxPattern; i++) send_word(ACT_PATTERN, motif[i % period]);
    repeat (2) send_word(ACT_PATTERN, 8'($urandom_range(0, 255)));

    // hold off until every outstanding result has drained
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);

    for (int i = 0; i < 80; i++)
      send_word(ACT_TEXT, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                      : motif[i % period]);

    // random: mostly short patterns scanned by text over the same small alphabet,
    // with some stray words mixed in and the odd burst of pure noise
    mark = sent_words;
    while (sent_words - mark < RandomWords) begin
      if ($urandom_range(0, 6) != 0) begin
        if ($urandom_range(0, 3) != 0) send_word(ACT_CLEAR, 8'($urandom_range(0, 255)));
        alpha_n = $urandom_range(1, 3);
        foreach (alpha[k]) alpha[k] = byte_t'($urandom_range(0, 255));
        plen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        repeat (plen) send_word(ACT_PATTERN, alpha[$urandom_range(0, alpha_n - 1)]);
        repeat ($urandom_range(10, 50)) begin
          case ($urandom_range(0, 19))
            0:       send_word(ActUnused, 8'($urandom_range(0, 255)));
            1:       send_word(ACT_PATTERN, alpha[$urandom_range(0, alpha_n - 1)]);
            2:       send_word(ACT_TEXT, 8'($urandom_range(0, 255)));
            default: send_word(ACT_TEXT, alpha[$urandom_range(0, alpha_n - 1)]);
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 5))
          send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end
    end

    // drain, then give any stray output word time to show up
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("words sent: %0d clear, %0d pattern, %0d text, %0d unused",
             sb.n_clear, sb.n_pattern, sb.n_text, sb.n_unused);
    $display("seen %0d whole matches, %0d dropped pattern bytes, longest length %0d, %0d errors",
             sb.n_full, sb.n_overflow, sb.max_len, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
src/kmp_pkg.sv
src/kmp_store.sv
src/kmp_stream_matcher.sv
test/kmp_stream_matcher_tb.sv
